### rtl/uf_pkg.sv
// Shared constants for the union-find engine.
package uf_pkg;

    localparam int NODE_COUNT_DEFAULT = 1024;

    // Width of a node index on the request ports
    localparam int NODE_W = 10;

    // Command codes
    localparam logic CMD_UNION = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

### rtl/uf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/union_find_engine.sv
// Union-find engine: top level with sequencer, shared compare/add unit and two RAMs.
// Reset: asynchronous; then a clearing pass over every node with in_ready low.
// A find walks S_LOOK, S_STEP and, per halving step, S_HALVE (one registered parent read port).
// Query: both finds, then S_RESOLVE and S_FIN; union: S_SIZE_A, S_SIZE_B and S_MERGE for the size merge.
// Out-of-range request: goes straight from S_IDLE to S_FIN. One request at a time.
// A finished answer waits in the output register while the next request is accepted.
module union_find_engine
    import uf_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              answer
);

    localparam int IdxW  = $clog2(NODE_COUNT);
    localparam int SizeW = $clog2(NODE_COUNT + 1);
    localparam logic [16:0] NodeLimit = 17'(NODE_COUNT);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NODE_COUNT - 1);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_LOOK    = 10'b00_0000_0100,
        S_STEP    = 10'b00_0000_1000,
        S_HALVE   = 10'b00_0001_0000,
        S_RESOLVE = 10'b00_0010_0000,
        S_SIZE_A  = 10'b00_0100_0000,
        S_SIZE_B  = 10'b00_1000_0000,
        S_MERGE   = 10'b01_0000_0000,
        S_FIN     = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [IdxW-1:0]   cur_reg, cur_next;
    logic [IdxW-1:0]   ra_reg, ra_next;
    logic [IdxW-1:0]   rb_reg, rb_next;
    logic [NODE_W-1:0] node_b_reg, node_b_next;
    logic              cmd_reg, cmd_next;
    logic              find_b_reg, find_b_next;
    logic [SizeW-1:0]  size_a_reg, size_a_next;
    logic              res_reg, res_next;
    logic [IdxW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              answer_reg, answer_next;

    // RAM ports
    logic              par_we;
    logic [IdxW-1:0]   par_wa, par_wd, par_ra, par_rdata;
    logic              size_we;
    logic [IdxW-1:0]   size_wa, size_ra;
    logic [SizeW-1:0]  size_wd, size_rdata;

    // Shared compare/add unit
    logic [SizeW-1:0]  op_x, op_y, u_sum;
    logic              u_eq, u_lt;

    logic              in_range;

    uf_ram #(
        .WIDTH (IdxW),
        .DEPTH (NODE_COUNT)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (par_we),
        .wr_addr (par_wa),
        .wr_data (par_wd),
        .rd_addr (par_ra),
        .rd_data (par_rdata)
    );

    uf_ram #(
        .WIDTH (SizeW),
        .DEPTH (NODE_COUNT)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (size_we),
        .wr_addr (size_wa),
        .wr_data (size_wd),
        .rd_addr (size_ra),
        .rd_data (size_rdata)
    );

    assign in_range = (17'(node_a) < NodeLimit) && (17'(node_b) < NodeLimit);

    always_comb
    begin
        op_x = '0;
        op_y = '0;
        unique case (state_reg)
            S_STEP:
            begin
                op_x = SizeW'(par_rdata);
                op_y = SizeW'(cur_reg);
            end
            S_RESOLVE:
            begin
                op_x = SizeW'(ra_reg);
                op_y = SizeW'(rb_reg);
            end
            S_MERGE:
            begin
                op_x = size_a_reg;
                op_y = size_rdata;
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign u_eq  = (op_x == op_y);
    assign u_lt  = (op_x < op_y);
    assign u_sum = op_x + op_y;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        node_b_next    = node_b_reg;
        cmd_next       = cmd_reg;
        find_b_next    = find_b_reg;
        size_a_next    = size_a_reg;
        res_next       = res_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        answer_next    = answer_reg;

        par_we  = 1'b0;
        par_wa  = cur_reg;
        par_wd  = par_rdata;
        par_ra  = cur_reg;
        size_we = 1'b0;
        size_wa = ra_reg;
        size_wd = u_sum;
        size_ra = ra_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                par_we       = 1'b1;
                par_wa       = clr_cnt_reg;
                par_wd       = clr_cnt_reg;
                size_we      = 1'b1;
                size_wa      = clr_cnt_reg;
                size_wd      = SizeW'(1);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LastIdx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    node_b_next = node_b;
                    cur_next    = IdxW'(node_a);
                    find_b_next = 1'b0;
                    res_next    = 1'b0;
                    state_next  = in_range ? S_LOOK : S_FIN;
                end
            end
            S_LOOK:
            begin
                par_ra     = cur_reg;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (u_eq)
                begin
                    if (!find_b_reg)
                    begin
                        ra_next     = cur_reg;
                        cur_next    = IdxW'(node_b_reg);
                        find_b_next = 1'b1;
                        state_next  = S_LOOK;
                    end
                    else
                    begin
                        rb_next    = cur_reg;
                        state_next = S_RESOLVE;
                    end
                end
                else
                begin
                    // fetch the grandparent
                    par_ra     = par_rdata;
                    state_next = S_HALVE;
                end
            end
            S_HALVE:
            begin
                // relink to grandparent and continue from there
                par_we     = 1'b1;
                par_wa     = cur_reg;
                par_wd     = par_rdata;
                par_ra     = par_rdata;
                cur_next   = par_rdata;
                state_next = S_STEP;
            end
            S_RESOLVE:
            begin
                res_next = (cmd_reg == CMD_QUERY) && u_eq;
                if (cmd_reg == CMD_UNION && !u_eq)
                begin
                    state_next = S_SIZE_A;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SIZE_A:
            begin
                size_ra    = ra_reg;
                state_next = S_SIZE_B;
            end
            S_SIZE_B:
            begin
                size_a_next = size_rdata;
                size_ra     = rb_reg;
                state_next  = S_MERGE;
            end
            S_MERGE:
            begin
                // smaller tree goes under the larger; ties keep node_a's root on top
                par_we  = 1'b1;
                size_we = 1'b1;
                par_wa  = u_lt ? ra_reg : rb_reg;
                par_wd  = u_lt ? rb_reg : ra_reg;
                size_wa = u_lt ? rb_reg : ra_reg;
                size_wd = u_sum;
                res_next   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    answer_next    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            find_b_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            find_b_reg    <= find_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        node_b_reg <= node_b_next;
        cmd_reg    <= cmd_next;
        size_a_reg <= size_a_next;
        res_reg    <= res_next;
        answer_reg <= answer_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;

endmodule

### rtl/uf_checker.sv
// Port-level checks for the union-find engine, bound to the top level.
module uf_checker
    import uf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              cmd,
    input logic [NODE_W-1:0] node_a,
    input logic [NODE_W-1:0] node_b,
    input logic              out_valid,
    input logic              out_ready,
    input logic              answer
);

    // Hold a stalled answer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(answer))
        else $error("answer changed or dropped while stalled");

    // Go busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one still in work");

    // A fresh answer only shows up after a busy cycle
    a_answer_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("answer appeared without work");

    // No answer pending right after reset is released
    a_no_answer_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("answer valid right after reset");

endmodule

bind union_find_engine uf_checker u_uf_checker (.*);
